### hdl/srp_pkg.sv
// srp_pkg: shared constants and types for the stun response parser
// used by srp_walker and stun_response_parser_unit; no dependencies
package srp_pkg;

  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusNotStun   = 3'd1;
  localparam logic [2:0] StatusNotOk     = 3'd2;
  localparam logic [2:0] StatusMalformed = 3'd3;
  localparam logic [2:0] StatusNoAddr    = 3'd4;

  localparam logic [31:0] MagicCookie    = 32'h2112_a442;
  localparam logic [15:0] PortXorMask    = 16'h2112;
  localparam logic [15:0] TypeSuccess    = 16'h0101;
  localparam logic [15:0] TypeMapped     = 16'h0001;
  localparam logic [15:0] TypeXorMapped  = 16'h0020;
  localparam logic [15:0] TypeXorMapped2 = 16'h8020;
  localparam logic [7:0]  FamilyV4       = 8'h01;
  localparam logic [7:0]  FamilyV6       = 8'h02;
  localparam logic [16:0] IndexMax       = 17'h1_ffff;

  // one decoded address attribute
  typedef struct packed {
    logic         found;
    logic [127:0] addr;
    logic [15:0]  port;
    logic         v6;
  } srp_addr_t;

  // per-byte control from the top level to the walker
  typedef struct packed {
    logic        step;
    logic        clear;
    logic        walk;
    logic [15:0] pos;
  } srp_walk_ctl_t;

endpackage

### hdl/srp_walker.sv
// srp_walker: attribute tlv walker and address decoder, one byte a cycle while ctl.step is high
// depends on srp_pkg
module srp_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  srp_pkg::srp_walk_ctl_t ctl,
  input  logic [7:0]             data_byte,
  input  logic [15:0]            attrs_length,
  input  logic [95:0]            txid,
  output logic                   walk_error,
  output srp_pkg::srp_addr_t     xor_rec,
  output srp_pkg::srp_addr_t     map_rec,
  output logic                   walk_error_next,
  output srp_pkg::srp_addr_t     xor_next,
  output srp_pkg::srp_addr_t     map_next
);

  logic [16:0]  attr_offset, attr_offset_next;
  logic [15:0]  attr_type, attr_type_next;
  logic [15:0]  attr_length, attr_length_next;
  logic [7:0]   attr_family, attr_family_next;
  logic [15:0]  attr_port, attr_port_next;
  logic [127:0] scratch, scratch_next;

  logic [16:0]  left;
  logic [16:0]  pad;
  logic [16:0]  k;
  logic [3:0]   sidx;
  logic         finish;
  logic [15:0]  f_len;
  logic [15:0]  f_port;
  logic [127:0] f_scr;
  logic         f_xor, f_map, f_v4, f_v6, f_ok;
  logic [127:0] f_mask, f_val, f_addr;

  assign left = {1'b0, attrs_length} - {1'b0, ctl.pos};
  assign k    = attr_offset - 17'd4;
  // scratch byte slot, wraps within the sixteen address bytes
  assign sidx = k[3:0] - 4'd4;

  // walk state update
  always_comb begin
    attr_offset_next = attr_offset;
    attr_type_next   = attr_type;
    attr_length_next = attr_length;
    attr_family_next = attr_family;
    attr_port_next   = attr_port;
    scratch_next     = scratch;
    walk_error_next  = walk_error;
    finish           = 1'b0;
    pad              = ({1'b0, attr_length} + 17'd3) & ~17'd3;
    f_len            = attr_length;
    f_port           = attr_port;
    f_scr            = scratch;
    if (ctl.walk) begin
      attr_offset_next = attr_offset + 17'd1;
      priority if (attr_offset == 17'd0) begin
        if (left < 17'd4) begin
          walk_error_next  = 1'b1;
          attr_offset_next = attr_offset;
        end else begin
          scratch_next     = '0;
          attr_family_next = '0;
          attr_port_next   = '0;
          attr_length_next = '0;
          attr_type_next   = {data_byte, 8'h00};
        end
      end else if (attr_offset == 17'd1) begin
        attr_type_next = {attr_type[15:8], data_byte};
      end else if (attr_offset == 17'd2) begin
        attr_length_next = {data_byte, 8'h00};
      end else if (attr_offset == 17'd3) begin
        attr_length_next = {attr_length[15:8], data_byte};
        f_len            = {attr_length[15:8], data_byte};
        pad              = ({1'b0, f_len} + 17'd3) & ~17'd3;
        if (pad > left - 17'd1) begin
          walk_error_next  = 1'b1;
          attr_offset_next = attr_offset;
        end else if (pad == 17'd0) begin
          finish           = 1'b1;
          attr_offset_next = '0;
        end
      end else begin
        if (k == 17'd1) attr_family_next = data_byte;
        else if (k == 17'd2) attr_port_next = {data_byte, attr_port[7:0]};
        else if (k == 17'd3) begin
          attr_port_next = {attr_port[15:8], data_byte};
          f_port         = {attr_port[15:8], data_byte};
        end else if (k >= 17'd4 && k < 17'd20) begin
          scratch_next[127 - 8*sidx -: 8] = data_byte;
        end
        f_scr = scratch_next;
        if (k + 17'd1 == pad) begin
          finish           = 1'b1;
          attr_offset_next = '0;
        end
      end
    end
  end

  // address decode at the end of an attribute
  always_comb begin
    f_xor  = attr_type == srp_pkg::TypeXorMapped || attr_type == srp_pkg::TypeXorMapped2;
    f_map  = attr_type == srp_pkg::TypeMapped;
    f_v4   = attr_family_next == srp_pkg::FamilyV4;
    f_v6   = attr_family_next == srp_pkg::FamilyV6;
    f_ok   = finish && (f_xor || f_map) && f_len >= 16'd4 &&
             ((f_v4 && f_len >= 16'd8) || (f_v6 && f_len >= 16'd20));
    f_mask = f_xor ? {srp_pkg::MagicCookie, txid} : '0;
    f_val  = f_scr ^ f_mask;
    f_addr = f_v6 ? f_val : {80'h0, 16'hffff, f_val[127:96]};
    xor_next = xor_rec;
    map_next = map_rec;
    if (f_ok && f_xor) begin
      xor_next = '{found: 1'b1, addr: f_addr, port: f_port ^ srp_pkg::PortXorMask, v6: f_v6};
    end
    if (f_ok && f_map) begin
      map_next = '{found: 1'b1, addr: f_addr, port: f_port, v6: f_v6};
    end
  end

  // walk registers, cleared after each message
  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.clear)) begin
      attr_offset <= '0;
      attr_type   <= '0;
      attr_length <= '0;
      attr_family <= '0;
      attr_port   <= '0;
      scratch     <= '0;
      walk_error  <= 1'b0;
      xor_rec     <= '0;
      map_rec     <= '0;
    end else if (ctl.step) begin
      attr_offset <= attr_offset_next;
      attr_type   <= attr_type_next;
      attr_length <= attr_length_next;
      attr_family <= attr_family_next;
      attr_port   <= attr_port_next;
      scratch     <= scratch_next;
      walk_error  <= walk_error_next;
      xor_rec     <= xor_next;
      map_rec     <= map_next;
    end
  end

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    attr_offset <= 17'd20 || attr_offset <= {1'b0, attr_length} + 17'd6)
    else $error("attribute offset past padded length");
  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    (walk_error && ctl.step && !ctl.clear) |=> walk_error)
    else $error("walk error dropped mid message");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (ctl.step && ctl.clear) |=> (!xor_rec.found && !map_rec.found && !walk_error))
    else $error("walker not cleared after message");

endmodule

### hdl/stun_response_parser_unit.sv
// stun_response_parser_unit: top level of the stun binding response parser
// depends on srp_pkg and srp_walker

// Takes one message byte a cycle when in_valid and in_ready are high; the
// byte carrying last_byte produces one result word, held in an output
// register until taken, and resets the parser for the next message. Each
// byte is handled combinationally by the header checks and the tlv walker
// between the parser state and the result register, so bytes stream back
// to back; input stalls only while a finished result is not yet taken and
// another last byte arrives.
module stun_response_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] txid_hi,
  output logic [63:0] txid_lo,
  output logic [63:0] addr_hi,
  output logic [63:0] addr_lo,
  output logic [15:0] mapped_port,
  output logic        is_ipv6
);

  logic [16:0] byte_index;
  logic [15:0] msg_type;
  logic [15:0] attrs_length;
  logic        header_bad;
  logic [95:0] txid;
  logic        accept;
  logic [17:0] total;
  logic [2:0]  status_next;
  logic [7:0]  cookie_byte;
  logic        walk_error;
  logic        bad_now;
  logic [15:0] type_now;
  logic [95:0] txid_now;
  logic        walk_err_now;
  srp_pkg::srp_walk_ctl_t ctl;
  srp_pkg::srp_addr_t     xor_rec, map_rec;
  srp_pkg::srp_addr_t     xor_now, map_now, sel_now;

  // a new byte may enter unless a result is stuck and this byte makes another
  assign in_ready = !out_valid || out_ready || !last_byte;
  assign accept   = in_valid && in_ready;
  assign total    = {1'b0, byte_index} + 18'd1;

  assign ctl.step  = accept;
  assign ctl.clear = last_byte;
  assign ctl.pos   = byte_index[15:0] - 16'd20;
  assign ctl.walk  = byte_index >= 17'd20 && !walk_error &&
                     (byte_index - 17'd20) < {1'b0, attrs_length};

  srp_walker u_walk (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .data_byte       (data_byte),
    .attrs_length    (attrs_length),
    .txid            (txid),
    .walk_error      (walk_error),
    .xor_rec         (xor_rec),
    .map_rec         (map_rec),
    .walk_error_next (walk_err_now),
    .xor_next        (xor_now),
    .map_next        (map_now)
  );

  always_comb begin
    unique case (byte_index[1:0])
      2'd0:    cookie_byte = srp_pkg::MagicCookie[31:24];
      2'd1:    cookie_byte = srp_pkg::MagicCookie[23:16];
      2'd2:    cookie_byte = srp_pkg::MagicCookie[15:8];
      default: cookie_byte = srp_pkg::MagicCookie[7:0];
    endcase
  end

  // header capture
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      byte_index   <= '0;
      msg_type     <= '0;
      attrs_length <= '0;
      header_bad   <= 1'b0;
      txid         <= '0;
    end else if (accept) begin
      if (byte_index != srp_pkg::IndexMax) byte_index <= byte_index + 17'd1;
      if (byte_index == 17'd0) begin
        msg_type[15:8] <= data_byte;
        if (data_byte[7:6] != 2'b00) header_bad <= 1'b1;
      end
      if (byte_index == 17'd1) msg_type[7:0] <= data_byte;
      if (byte_index == 17'd2) attrs_length[15:8] <= data_byte;
      if (byte_index == 17'd3) attrs_length[7:0] <= data_byte;
      if (byte_index >= 17'd4 && byte_index < 17'd8 && data_byte != cookie_byte)
        header_bad <= 1'b1;
      if (byte_index >= 17'd8 && byte_index < 17'd20)
        txid[95 - 8*(byte_index[4:0] - 5'd8) -: 8] <= data_byte;
    end
  end

  // the last byte may itself finish an attribute; the walker's next state counts
  assign sel_now = xor_now.found ? xor_now : map_now;

  // final status for the last byte (header bytes of this byte matter too)
  always_comb begin
    bad_now  = header_bad ||
               (byte_index == 17'd0 && data_byte[7:6] != 2'b00) ||
               (byte_index >= 17'd4 && byte_index < 17'd8 && data_byte != cookie_byte);
    type_now = (byte_index == 17'd1) ? {msg_type[15:8], data_byte} : msg_type;
    txid_now = txid;
    if (byte_index == 17'd19) txid_now[7:0] = data_byte;
    priority if (total < 18'd20 || bad_now) status_next = srp_pkg::StatusNotStun;
    else if (type_now != srp_pkg::TypeSuccess) status_next = srp_pkg::StatusNotOk;
    else if ({2'b00, attrs_length} > total - 18'd20 || walk_err_now)
      status_next = srp_pkg::StatusMalformed;
    else if (xor_now.found || map_now.found) status_next = srp_pkg::StatusOk;
    else status_next = srp_pkg::StatusNoAddr;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (accept && last_byte) begin
      status      <= status_next;
      txid_hi     <= (status_next == srp_pkg::StatusNotStun) ? '0 : txid_now[95:64];
      txid_lo     <= (status_next == srp_pkg::StatusNotStun) ? '0 : txid_now[63:0];
      addr_hi     <= (status_next == srp_pkg::StatusOk) ? sel_now.addr[127:64] : '0;
      addr_lo     <= (status_next == srp_pkg::StatusOk) ? sel_now.addr[63:0] : '0;
      mapped_port <= (status_next == srp_pkg::StatusOk) ? sel_now.port : '0;
      is_ipv6     <= (status_next == srp_pkg::StatusOk) && sel_now.v6;
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_valid && last_byte) |-> !in_ready)
    else $error("result would be overwritten");
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (byte_index == 17'd0 && out_valid))
    else $error("parser not restarted after last byte");
  a_prefer_xor: assert property (@(posedge clk) disable iff (rst)
    (xor_now.found) |-> (sel_now.port == xor_now.port))
    else $error("xor address not preferred");

endmodule
